[hdl/bamm_pkg.sv]
// ----------------------------------------------------------------------------
// bamm_pkg: shared types and constants for the burst average/min/max sampler
// Holds the payload structs, the phase encoding, the configuration indexes
// and the widths that follow from the averaging window.
// ----------------------------------------------------------------------------
package bamm_pkg;

	// Averaging window (ring depth), legal range 1 to 64
	localparam int AVG_LEN = 8;

	localparam int SAMPLE_W = 12;
	localparam int LEVEL_W  = 13;
	localparam int SEC_W    = 6;
	localparam int PERIOD_W = 6;
	localparam int LENGTH_W = 10;
	localparam int CNT_W    = LENGTH_W;
	localparam int IDX_W    = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;
	localparam int SUM_W    = SAMPLE_W + $clog2(AVG_LEN);
	localparam int CFG_IDX_W = 1;

	localparam logic [SEC_W:0]     SEC_PER_MIN = 7'd60;
	localparam logic [LEVEL_W-1:0] MIN_NONE    = 13'd4096;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 6'd10;
	localparam logic [LENGTH_W-1:0] LENGTH_RESET = 10'd64;

	// Request codes
	localparam logic REQ_TIME   = 1'b0;
	localparam logic REQ_SAMPLE = 1'b1;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GAP_SECS     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BURST_LENGTH = 1'd1;

	typedef enum logic [1:0] {
		PH_IDLE    = 2'd0,
		PH_PRELOAD = 2'd1,
		PH_MEASURE = 2'd2
	} phase_t;

	typedef struct packed {
		logic                req_type;
		logic [SEC_W-1:0]    now_second;
		logic [SAMPLE_W-1:0] sample;
	} in_item_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] max_level;
		logic [LEVEL_W-1:0]  min_level;
		logic                burst_active;
		logic                burst_done;
	} out_item_t;

	typedef struct packed {
		logic [PERIOD_W-1:0] gap_secs;
		logic [LENGTH_W-1:0] burst_length;
	} cfg_t;

endpackage

[hdl/burst_average_min_max.sv]
// ----------------------------------------------------------------------------
// burst_average_min_max: periodic burst sampler with boxcar average and peaks
// Starts a burst on a due time check, preloads the averaging ring, then
// reports the running max and min of the truncated average per sample.
// ----------------------------------------------------------------------------
//
//  Channel   Signals                                   Direction
//  --------  ----------------------------------------  ---------
//  input     in_valid, in_ready, in_data (in_item_t)   sink
//  result    out_valid, out_ready, out_data (out_item_t) source
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data sink
//
//  Throughput is one transaction per cycle unless the result stalls; an
//  item passes the input register, state update, then result register.
//  Reset clears the burst state, the ring, and loads the register defaults.
//  A stalled result holds the result register and the input register; input
//  is still taken while the input register is empty.
//  Configuration writes are always taken and are registered in cfg_q.
//
module burst_average_min_max import bamm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [LENGTH_W-1:0]  cfg_data
);

	cfg_t      cfg_q;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      out_valid_q;
	out_item_t out_data_q;
	out_item_t result;
	logic      advance;
	logic      step;

	// Advance when the result register is empty or drains this cycle
	assign advance  = !out_valid_q || out_ready;
	// Take input when the input register is empty or moves forward
	assign in_ready = !valid_s1 || advance;
	// Commit the item's state update as it enters the result register
	assign step     = valid_s1 && advance;

	assign cfg_ready = 1'b1;

	// Hold configuration registers; decode the index by name
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gap_secs     <= PERIOD_RESET;
			cfg_q.burst_length <= LENGTH_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_GAP_SECS: cfg_q.gap_secs <= cfg_data[PERIOD_W-1:0];
				CFG_BURST_LENGTH: cfg_q.burst_length <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	bamm_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Checks

	// An item leaving the input register always shows up as a result
	a_step_loads: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> out_valid)
		else $error("committed item did not reach the result register");

	// An accepted transaction occupies the input register next cycle
	a_in_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> valid_s1)
		else $error("accepted transaction lost before the input register");

	// The completing item already reports the burst as over
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.burst_done && out_data.burst_active))
		else $error("burst_done reported with burst still active");

	// Once any average is recorded the minimum cannot exceed the maximum
	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.min_level != MIN_NONE)
		|-> out_data.min_level <= {1'b0, out_data.max_level})
		else $error("min_level above max_level");

endmodule

[hdl/bamm_core.sv]
// ----------------------------------------------------------------------------
// bamm_core: burst state, sample ring and peak tracking
// Forms the result of one item from the current state in one pass and
// commits the new state when the item moves to the result register.
// ----------------------------------------------------------------------------
module bamm_core import bamm_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t result
);

	phase_t              phase_q, phase_d;
	logic [SAMPLE_W-1:0] ring_q [AVG_LEN];
	logic [IDX_W-1:0]    idx_q, idx_d;
	logic [SUM_W-1:0]    sum_q, sum_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [SAMPLE_W-1:0] high_q, high_d;
	logic [LEVEL_W-1:0]  low_q, low_d;
	logic [SEC_W-1:0]    last_q, last_d;

	logic [SAMPLE_W-1:0] oldest;
	logic [IDX_W-1:0]    idx_inc;
	logic [CNT_W-1:0]    count_inc;
	logic [SUM_W-1:0]    sum_meas;
	logic [SAMPLE_W-1:0] avg;
	logic [SEC_W:0]      limit;
	logic                due;
	logic                is_sample;
	logic                preload_last;
	logic                measure_last;
	logic                ring_we;
	logic                done;

	assign is_sample = (item.req_type == REQ_SAMPLE);
	assign oldest    = ring_q[idx_q];
	assign idx_inc   = (idx_q == IDX_W'(AVG_LEN - 1)) ? '0 : idx_q + IDX_W'(1);
	assign count_inc = count_q + CNT_W'(1);
	assign sum_meas  = sum_q - SUM_W'(oldest) + SUM_W'(item.sample);
	assign avg       = SAMPLE_W'(sum_meas / SUM_W'(AVG_LEN));

	// Wrap past the minute: compare now+60 against last+period
	assign limit = {1'b0, last_q} + {1'b0, cfg.gap_secs};
	always_comb begin
		if (item.now_second < last_q) begin
			due = ({1'b0, item.now_second} + SEC_PER_MIN) > limit;
		end else begin
			due = {1'b0, item.now_second} > limit;
		end
	end

	assign preload_last = count_inc >= CNT_W'(AVG_LEN);
	assign measure_last = count_inc >= cfg.burst_length;

	// Next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_IDLE: begin
				if (!is_sample && due) begin
					phase_d = PH_PRELOAD;
				end
			end
			PH_PRELOAD: begin
				if (is_sample && preload_last) begin
					phase_d = (cfg.burst_length == '0) ? PH_IDLE : PH_MEASURE;
				end
			end
			PH_MEASURE: begin
				if (is_sample && measure_last) begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// Datapath and result
	always_comb begin
		idx_d   = idx_q;
		sum_d   = sum_q;
		count_d = count_q;
		high_d  = high_q;
		low_d   = low_q;
		last_d  = last_q;
		ring_we = 1'b0;
		done    = 1'b0;
		case (phase_q)
			PH_IDLE: begin
				if (!is_sample && due) begin
					high_d  = '0;
					low_d   = MIN_NONE;
					idx_d   = '0;
					sum_d   = '0;
					count_d = '0;
					last_d  = item.now_second;
				end
			end
			PH_PRELOAD: begin
				if (is_sample) begin
					ring_we = 1'b1;
					sum_d   = sum_q + SUM_W'(item.sample);
					if (preload_last) begin
						idx_d   = '0;
						count_d = '0;
						done    = (cfg.burst_length == '0);
					end else begin
						idx_d   = idx_inc;
						count_d = count_inc;
					end
				end
			end
			PH_MEASURE: begin
				if (is_sample) begin
					ring_we = 1'b1;
					sum_d   = sum_meas;
					idx_d   = idx_inc;
					count_d = count_inc;
					if (avg > high_q) begin
						high_d = avg;
					end
					if ({1'b0, avg} < low_q) begin
						low_d = {1'b0, avg};
					end
					done = measure_last;
				end
			end
			default: begin
			end
		endcase
		result.max_level    = high_d;
		result.min_level    = low_d;
		result.burst_active = (phase_d != PH_IDLE);
		result.burst_done   = done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			idx_q   <= '0;
			sum_q   <= '0;
			count_q <= '0;
			high_q  <= '0;
			low_q   <= MIN_NONE;
			last_q  <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			idx_q   <= idx_d;
			sum_q   <= sum_d;
			count_q <= count_d;
			high_q  <= high_d;
			low_q   <= low_d;
			last_q  <= last_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < AVG_LEN; i++) begin
				ring_q[i] <= '0;
			end
		end else if (step && ring_we) begin
			ring_q[idx_q] <= item.sample;
		end
	end

endmodule
